// File: rtl/core/bbsr_pkg.sv
// Shared types and constants for the billboard sprite rasterizer.
package bbsr_pkg;

  localparam int unsigned TEXEL_BITS = 32;
  localparam int unsigned NUM_W = 48;
  localparam int unsigned DEN_W = 32;
  localparam logic [TEXEL_BITS-1:0] TRANSPARENT_KEY = 32'hFF000000;
  localparam logic [30:0] SPAN_MAX = 31'h7FFFFFFF;

  typedef enum logic [1:0] {
    ACT_DEPTH = 2'd0,
    ACT_TEXEL = 2'd1,
    ACT_START = 2'd2,
    ACT_TICK  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_T0,
    S_T1,
    S_T2
  } state_t;

  typedef enum logic [2:0] {
    OP_MID,
    OP_H,
    OP_W,
    OP_SU,
    OP_SV
  } div_op_t;

  typedef enum logic {
    REG_TEX_WIDTH  = 1'b0,
    REG_TEX_HEIGHT = 1'b1
  } reg_idx_t;

endpackage

// File: rtl/core/bbsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bbsr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 640
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/bbsr_div.sv
// Restoring divider, one quotient bit per cycle.
module bbsr_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bbsr_pkg::NUM_W-1:0] num,
  input  logic [bbsr_pkg::DEN_W-1:0] den,
  output logic [bbsr_pkg::NUM_W-1:0] quot,
  output logic                       done
);

  localparam int unsigned CW = $clog2(bbsr_pkg::NUM_W);

  logic [bbsr_pkg::DEN_W:0]   rem;
  logic [bbsr_pkg::DEN_W-1:0] den_q;
  logic [CW-1:0]              cnt;
  logic                       running;
  logic [bbsr_pkg::DEN_W:0]   rem_sh;
  logic [bbsr_pkg::DEN_W+1:0] diff;

  assign rem_sh = {rem[bbsr_pkg::DEN_W-1:0], quot[bbsr_pkg::NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        if (cnt == CW'(bbsr_pkg::NUM_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quot  <= num;
      den_q <= den;
    end else if (running) begin
      if (!diff[bbsr_pkg::DEN_W+1]) begin
        rem  <= diff[bbsr_pkg::DEN_W:0];
        quot <= {quot[bbsr_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        quot <= {quot[bbsr_pkg::NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/core/billboard_sprite_rasterizer_top.sv
// Top level of the billboard sprite rasterizer: sequencer, stores, divider.
//
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+----------------------------------------
// input    | in_valid / in_ready         | action slot_index word_value sprite_x
//          |                             | sprite_depth size_scale
// output   | out_valid / out_ready       | pixel_valid pixel_x pixel_y pixel_color
//          |                             | sprite_done
// config   | psel penable pwrite pready  | paddr pwdata prdata
//
// Depth and texel writes are taken in S_IDLE. A pixel tick runs S_T0, S_T1,
// S_T2 (address, depth read, texel read, result); an idle tick answers from
// S_IDLE. A sprite start runs up to five divisions through one restoring
// divider, each with launch and hand-off; a zero height or width ends the
// run early. Reset is synchronous and clears control state only; the stores
// need no clearing pass. A stalled result holds the input side off until taken.
module billboard_sprite_rasterizer_top #(
  parameter int unsigned SCREEN_W = 640,
  parameter int unsigned SCREEN_H = 480,
  parameter int unsigned TEX_DIM  = 64
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [11:0] slot_index,
  input  logic [31:0] word_value,
  input  logic signed [31:0] sprite_x,
  input  logic signed [31:0] sprite_depth,
  input  logic [15:0] size_scale,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        pixel_valid,
  output logic [9:0]  pixel_x,
  output logic [8:0]  pixel_y,
  output logic [31:0] pixel_color,
  output logic        sprite_done,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned TEX_CELLS = TEX_DIM * TEX_DIM;
  localparam int unsigned DAW = $clog2(SCREEN_W);
  localparam int unsigned TAW = $clog2(TEX_CELLS);
  localparam int unsigned MID_SCALE = SCREEN_W / 2;
  localparam int unsigned H_SCALE = SCREEN_H * 256;
  localparam int unsigned HALF_H = SCREEN_H / 2;

  // ---------------- configuration registers ----------------
  logic [6:0] tex_width;
  logic [6:0] tex_height;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= 7'd64;
      tex_height <= 7'd64;
    end else if (cfg_we) begin
      case (bbsr_pkg::reg_idx_t'(paddr[2]))
        bbsr_pkg::REG_TEX_WIDTH:  tex_width  <= pwdata[6:0];
        bbsr_pkg::REG_TEX_HEIGHT: tex_height <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (bbsr_pkg::reg_idx_t'(paddr[2]))
      bbsr_pkg::REG_TEX_WIDTH:  prdata = {25'b0, tex_width};
      bbsr_pkg::REG_TEX_HEIGHT: prdata = {25'b0, tex_height};
      default:                  prdata = '0;
    endcase
  end

  // ---------------- state ----------------
  bbsr_pkg::state_t  state, state_next;
  bbsr_pkg::div_op_t op;

  logic signed [31:0] sx;
  logic signed [31:0] sy;
  logic [15:0]        scale;
  logic               mid_neg;
  logic signed [48:0] mid_val;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic [30:0]        span_w;
  logic [30:0]        span_h;
  logic [31:0]        step_u;
  logic [31:0]        step_v;
  logic [30:0]        held_depth;
  logic [30:0]        col_pos;
  logic [30:0]        row_pos;
  logic               busy;

  // tick pipeline
  logic [63:0]        prod_u;
  logic [63:0]        prod_v;
  logic [33:0]        cx_q;
  logic [33:0]        cy_q;
  logic               on_screen;
  logic               vis;
  logic               addr_ok;

  logic acc;
  assign acc = in_valid && in_ready;
  assign in_ready = (state == bbsr_pkg::S_IDLE) && (!out_valid || out_ready);

  // ---------------- stores ----------------
  logic              depth_we, tex_we;
  logic [DAW-1:0]    depth_raddr;
  logic [31:0]       depth_rd;
  logic [TAW-1:0]    tex_raddr;
  logic [31:0]       tex_rd;

  assign depth_we = acc && (bbsr_pkg::action_t'(action) == bbsr_pkg::ACT_DEPTH)
                    && ({20'b0, slot_index} < 32'(SCREEN_W));
  assign tex_we   = acc && (bbsr_pkg::action_t'(action) == bbsr_pkg::ACT_TEXEL)
                    && ({20'b0, slot_index} < 32'(TEX_CELLS));

  bbsr_ram #(.WIDTH(32), .DEPTH(SCREEN_W)) u_depth_ram (
    .clk   (clk),
    .we    (depth_we),
    .waddr (DAW'(slot_index)),
    .wdata (word_value),
    .raddr (depth_raddr),
    .rdata (depth_rd)
  );

  bbsr_ram #(.WIDTH(bbsr_pkg::TEXEL_BITS), .DEPTH(TEX_CELLS)) u_texel_ram (
    .clk   (clk),
    .we    (tex_we),
    .waddr (TAW'(slot_index)),
    .wdata (word_value),
    .raddr (tex_raddr),
    .rdata (tex_rd)
  );

  // ---------------- shared divider ----------------
  logic                         div_start;
  logic [bbsr_pkg::NUM_W-1:0]   div_num;
  logic [bbsr_pkg::DEN_W-1:0]   div_den;
  logic [bbsr_pkg::NUM_W-1:0]   div_quot;
  logic                         div_done;

  logic signed [32:0] sum33;
  logic signed [47:0] mid_num_s;
  logic [47:0]        mid_abs;

  assign sum33     = 33'(sx) + 33'(sy);
  assign mid_num_s = 48'(sum33) * $signed(48'(MID_SCALE));
  assign mid_abs   = mid_num_s[47] ? 48'(-mid_num_s) : 48'(mid_num_s);

  always_comb begin
    case (op)
      bbsr_pkg::OP_MID: begin
        div_num = mid_abs;
        div_den = sy;
      end
      bbsr_pkg::OP_H: begin
        div_num = 48'(H_SCALE) * {32'b0, scale};
        div_den = sy;
      end
      bbsr_pkg::OP_W: begin
        div_num = {41'b0, tex_width} * {17'b0, span_h};
        div_den = {25'b0, tex_height};
      end
      bbsr_pkg::OP_SU: begin
        div_num = {25'b0, tex_width, 16'b0};
        div_den = {1'b0, span_w};
      end
      bbsr_pkg::OP_SV: begin
        div_num = {25'b0, tex_height, 16'b0};
        div_den = {1'b0, span_h};
      end
      default: begin
        div_num = '0;
        div_den = 32'd1;
      end
    endcase
  end

  assign div_start = (state == bbsr_pkg::S_DIV_GO);

  bbsr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_quot),
    .done  (div_done)
  );

  // saturated division result and origin math
  logic [30:0]        q_sat;
  logic signed [49:0] ox_full;
  logic signed [31:0] ox_clamp;

  assign q_sat   = (|div_quot[47:31]) ? bbsr_pkg::SPAN_MAX : div_quot[30:0];
  assign ox_full = 50'(mid_val) - $signed({19'b0, q_sat[30:1]});
  assign ox_clamp = (ox_full > 50'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                    (ox_full < -50'sh80000000) ? -32'sh80000000 : ox_full[31:0];

  // ---------------- tick datapath ----------------
  logic [33:0] cx, cy;
  logic        cx_ok, cy_ok;
  logic [47:0] u_val, v_val;
  logic [24:0] addr_full;
  logic        addr_big;
  logic [31:0] color;
  logic        last_row, last_col;

  assign cx    = 34'(origin_x) + {3'b0, col_pos};
  assign cy    = 34'(origin_y) + {3'b0, row_pos};
  assign cx_ok = !cx[33] && (cx < 34'(SCREEN_W));
  assign cy_ok = !cy[33] && (cy < 34'(SCREEN_H));
  assign depth_raddr = cx[DAW-1:0];

  assign u_val     = prod_u[63:16];
  assign v_val     = prod_v[63:16];
  assign addr_full = 25'(v_val[16:0] * {10'b0, tex_width}) + {8'b0, u_val[16:0]};
  assign addr_big  = (|u_val[47:17]) || ((|v_val[47:17]) && (tex_width != 7'd0));
  assign tex_raddr = addr_full[TAW-1:0];

  assign color    = addr_ok ? tex_rd : '0;
  assign last_row = (row_pos + 31'd1) >= span_h;
  assign last_col = (col_pos + 31'd1) >= span_w;

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) state <= bbsr_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      bbsr_pkg::S_IDLE: begin
        if (acc) begin
          case (bbsr_pkg::action_t'(action))
            bbsr_pkg::ACT_START:
              if (sprite_depth > 32'sd0 && tex_width != 7'd0 && tex_height != 7'd0)
                state_next = bbsr_pkg::S_DIV_GO;
            bbsr_pkg::ACT_TICK:
              if (busy) state_next = bbsr_pkg::S_T0;
            default: ;
          endcase
        end
      end
      bbsr_pkg::S_DIV_GO: state_next = bbsr_pkg::S_DIV_WAIT;
      bbsr_pkg::S_DIV_WAIT: begin
        if (div_done) begin
          case (op)
            bbsr_pkg::OP_W:
              state_next = (span_h == 31'd0 || q_sat == 31'd0) ? bbsr_pkg::S_IDLE
                                                                : bbsr_pkg::S_DIV_GO;
            bbsr_pkg::OP_SV: state_next = bbsr_pkg::S_IDLE;
            default:         state_next = bbsr_pkg::S_DIV_GO;
          endcase
        end
      end
      bbsr_pkg::S_T0: state_next = bbsr_pkg::S_T1;
      bbsr_pkg::S_T1: state_next = bbsr_pkg::S_T2;
      bbsr_pkg::S_T2: state_next = bbsr_pkg::S_IDLE;
      default:        state_next = bbsr_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      col_pos   <= '0;
      row_pos   <= '0;
      origin_x  <= '0;
      origin_y  <= '0;
      span_w    <= '0;
      span_h    <= '0;
      step_u    <= '0;
      step_v    <= '0;
      held_depth <= '0;
      op        <= bbsr_pkg::OP_MID;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        bbsr_pkg::S_IDLE: begin
          if (acc && bbsr_pkg::action_t'(action) == bbsr_pkg::ACT_START) begin
            busy    <= 1'b0;
            col_pos <= '0;
            row_pos <= '0;
            op      <= bbsr_pkg::OP_MID;
          end
          // idle tick answers at once
          if (acc && bbsr_pkg::action_t'(action) == bbsr_pkg::ACT_TICK && !busy) begin
            out_valid <= 1'b1;
          end
        end
        bbsr_pkg::S_DIV_WAIT: begin
          if (div_done) begin
            case (op)
              bbsr_pkg::OP_MID: op <= bbsr_pkg::OP_H;
              bbsr_pkg::OP_H: begin
                span_h <= q_sat;
                op     <= bbsr_pkg::OP_W;
              end
              bbsr_pkg::OP_W: begin
                span_w   <= q_sat;
                origin_x <= ox_clamp;
                origin_y <= 32'(33'(HALF_H) - {3'b0, span_h[30:1]});
                op       <= bbsr_pkg::OP_SU;
              end
              bbsr_pkg::OP_SU: begin
                step_u <= div_quot[31:0];
                op     <= bbsr_pkg::OP_SV;
              end
              bbsr_pkg::OP_SV: begin
                step_v     <= div_quot[31:0];
                held_depth <= sy[30:0];
                busy       <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        bbsr_pkg::S_T2: begin
          out_valid <= 1'b1;
          if (last_row) begin
            row_pos <= '0;
            if (last_col) begin
              col_pos <= '0;
              busy    <= 1'b0;
            end else begin
              col_pos <= col_pos + 31'd1;
            end
          end else begin
            row_pos <= row_pos + 31'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == bbsr_pkg::S_IDLE && acc) begin
      sx    <= sprite_x;
      sy    <= sprite_depth;
      scale <= size_scale;
    end
    if (state == bbsr_pkg::S_DIV_WAIT && div_done && op == bbsr_pkg::OP_MID) begin
      mid_val <= mid_neg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
    end
    if (state == bbsr_pkg::S_DIV_GO && op == bbsr_pkg::OP_MID) begin
      mid_neg <= mid_num_s[47];
    end
    if (state == bbsr_pkg::S_T0) begin
      prod_u    <= {32'b0, step_u} * {33'b0, col_pos};
      prod_v    <= {32'b0, step_v} * {33'b0, row_pos};
      cx_q      <= cx;
      cy_q      <= cy;
      on_screen <= cx_ok && cy_ok;
    end
    if (state == bbsr_pkg::S_T1) begin
      vis     <= on_screen && (depth_rd > {1'b0, held_depth});
      addr_ok <= !addr_big && (addr_full < 25'(TEX_CELLS));
    end
    if (state == bbsr_pkg::S_IDLE && acc && bbsr_pkg::action_t'(action) == bbsr_pkg::ACT_TICK
        && !busy) begin
      pixel_valid <= 1'b0;
      pixel_x     <= '0;
      pixel_y     <= '0;
      pixel_color <= '0;
      sprite_done <= 1'b1;
    end
    if (state == bbsr_pkg::S_T2) begin
      if (vis && color != bbsr_pkg::TRANSPARENT_KEY) begin
        pixel_valid <= 1'b1;
        pixel_x     <= cx_q[9:0];
        pixel_y     <= cy_q[8:0];
        pixel_color <= color;
      end else begin
        pixel_valid <= 1'b0;
        pixel_x     <= '0;
        pixel_y     <= '0;
        pixel_color <= '0;
      end
      sprite_done <= last_row && last_col;
    end
  end

endmodule

// File: rtl/core/bbsr_checker.sv
// Port-level checker for the billboard sprite rasterizer, bound to the top.
module bbsr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  action,
  input logic        out_valid,
  input logic        out_ready,
  input logic        pixel_valid,
  input logic [9:0]  pixel_x,
  input logic [8:0]  pixel_y,
  input logic [31:0] pixel_color
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_no_result_for_writes: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && action != bbsr_pkg::ACT_TICK |=> !out_valid)
    else $error("result produced for a non-tick transaction");

  a_blank_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pixel_valid |-> pixel_x == 10'd0 && pixel_y == 9'd0 && pixel_color == 32'd0)
    else $error("fields not zero on an empty tick");

  a_key_hidden: assert property (@(posedge clk) disable iff (rst)
    out_valid && pixel_valid |-> pixel_color != bbsr_pkg::TRANSPARENT_KEY)
    else $error("transparent texel drawn");

endmodule

bind billboard_sprite_rasterizer_top bbsr_checker u_bbsr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .action      (action),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .pixel_valid (pixel_valid),
  .pixel_x     (pixel_x),
  .pixel_y     (pixel_y),
  .pixel_color (pixel_color)
);

// File: bench/billboard_sprite_rasterizer_tb.sv
// Testbench for the billboard sprite rasterizer: preload, directed and random traffic.
`timescale 1ns / 1ps

typedef struct {
  bbsr_pkg::action_t act;
  logic [11:0] slot;
  logic [31:0] word;
  logic [31:0] sx;
  logic [31:0] sdepth;
  logic [15:0] scale;
} raster_cmd_t;

typedef struct {
  logic        vis;
  logic [9:0]  px;
  logic [8:0]  py;
  logic [31:0] color;
  logic        done;
} pixel_write_t;

class pixel_scoreboard;
  localparam int SCR_W = 640;
  localparam int SCR_H = 480;
  localparam int CELLS = 64 * 64;

  pixel_write_t pending[$];
  int errors;
  int unsigned tw, th;
  logic [31:0] wall_depth[SCR_W];
  logic [31:0] texels[CELLS];
  longint org_x, org_y, held;
  longint unsigned wspan, hspan;
  int unsigned su, sv, col, row;
  bit busy;

  function new();
    errors = 0;
    tw = 64;
    th = 64;
    org_x = 0;
    org_y = 0;
    held = 0;
    wspan = 0;
    hspan = 0;
    su = 0;
    sv = 0;
    col = 0;
    row = 0;
    busy = 0;
  endfunction

  task report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function void set_reg(bbsr_pkg::reg_idx_t idx, logic [31:0] val);
    if (idx == bbsr_pkg::REG_TEX_WIDTH) tw = val[6:0];
    else th = val[6:0];
  endfunction

  function void project(longint sx, longint sy, longint unsigned sc);
    longint mid;
    longint unsigned h, w;
    busy = 0;
    col = 0;
    row = 0;
    if (sy <= 0 || tw == 0 || th == 0) return;
    mid = (longint'(SCR_W / 2) * (sx + sy)) / sy;
    h = (longint'(SCR_H) * 256 * sc) / longint'(sy);
    if (h > 64'h7FFFFFFF) h = 64'h7FFFFFFF;
    w = (longint'(tw) * h) / th;
    if (w > 64'h7FFFFFFF) w = 64'h7FFFFFFF;
    if (h == 0 || w == 0) return;
    hspan = h;
    wspan = w;
    org_x = mid - longint'(w / 2);
    if (org_x > 64'sh7FFFFFFF) org_x = 64'sh7FFFFFFF;
    if (org_x < -64'sh80000000) org_x = -64'sh80000000;
    org_y = longint'(SCR_H / 2) - longint'(h / 2);
    if (org_y < -64'sh80000000) org_y = -64'sh80000000;
    su = (longint'(tw) << 16) / w;
    sv = (longint'(th) << 16) / h;
    held = sy;
    busy = 1;
  endfunction

  // Called on every accepted input transaction.
  function void note(raster_cmd_t c);
    pixel_write_t e;
    longint cx, cy;
    longint unsigned u, v, addr;
    logic [31:0] texel;
    case (c.act)
      bbsr_pkg::ACT_DEPTH: if (c.slot < SCR_W) wall_depth[c.slot] = c.word;
      bbsr_pkg::ACT_TEXEL: if (c.slot < CELLS) texels[c.slot] = c.word;
      bbsr_pkg::ACT_START: project(longint'(signed'(c.sx)), longint'(signed'(c.sdepth)),
                                   longint'(c.scale));
      default: begin
        e = '{vis: 0, px: 0, py: 0, color: 0, done: 1};
        if (busy) begin
          cx = org_x + longint'(col);
          cy = org_y + longint'(row);
          if (cx >= 0 && cx < SCR_W && longint'(wall_depth[cx]) > held
              && cy >= 0 && cy < SCR_H) begin
            u = (longint'(su) * longint'(col)) >> 16;
            v = (longint'(sv) * longint'(row)) >> 16;
            addr = v * tw + u;
            texel = (addr < CELLS) ? texels[addr] : 32'h0;
            if (texel != bbsr_pkg::TRANSPARENT_KEY) begin
              e.vis = 1;
              e.px = cx[9:0];
              e.py = cy[8:0];
              e.color = texel;
            end
          end
          e.done = 0;
          row++;
          if (row >= hspan) begin
            row = 0;
            col++;
            if (col >= wspan) begin
              col = 0;
              busy = 0;
              e.done = 1;
            end
          end
        end
        pending.push_back(e);
      end
    endcase
  endfunction

  task check(pixel_write_t got);
    pixel_write_t e;
    if (pending.size() == 0) begin
      report("result with nothing expected");
      return;
    end
    e = pending.pop_front();
    if (got.vis !== e.vis) report($sformatf("pixel_valid %0b exp %0b", got.vis, e.vis));
    if (got.px !== e.px) report($sformatf("pixel_x %0d exp %0d", got.px, e.px));
    if (got.py !== e.py) report($sformatf("pixel_y %0d exp %0d", got.py, e.py));
    if (got.color !== e.color)
      report($sformatf("pixel_color %h exp %h", got.color, e.color));
    if (got.done !== e.done) report($sformatf("sprite_done %0b exp %0b", got.done, e.done));
  endtask
endclass

module testbench;
  localparam int LIMIT = 900000;   // cycles; slowest clean run is far below this
  localparam int SETTLE = 400;     // covers one sprite start (five divisions)
  // Sprites are kept small and near the center, so only this column window
  // and the first 64 texels are ever read.
  localparam int COL_LO = 240;
  localparam int COL_HI = 400;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] action = bbsr_pkg::ACT_DEPTH;
  logic [11:0] slot_index = 0;
  logic [31:0] word_value = 0;
  logic signed [31:0] sprite_x = 0;
  logic signed [31:0] sprite_depth = 0;
  logic [15:0] size_scale = 0;
  logic out_valid;
  logic out_ready = 0;
  logic pixel_valid;
  logic [9:0] pixel_x;
  logic [8:0] pixel_y;
  logic [31:0] pixel_color;
  logic sprite_done;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;

  pixel_scoreboard sb = new();
  int send_idle_pct = 0;   // percent of cycles the sender idles
  int recv_idle_pct = 0;   // percent of cycles with out_ready low
  int cycles = 0;

  billboard_sprite_rasterizer_top dut (.*);

  always #6 clk = ~clk;

  // Receiver: random back-pressure per cycle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Output monitor: every accepted result goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check('{vis: pixel_valid, px: pixel_x, py: pixel_y,
                 color: pixel_color, done: sprite_done});
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL billboard_sprite_rasterizer_top");
      $finish;
    end
  end

  // Drive one input transaction. in_valid is only dropped when a gap
  // follows, so back-to-back transactions keep it high.
  task send(raster_cmd_t c);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1;
    action <= c.act;
    slot_index <= c.slot;
    word_value <= c.word;
    sprite_x <= c.sx;
    sprite_depth <= c.sdepth;
    size_scale <= c.scale;
    do @(posedge clk); while (!in_ready);
    sb.note(c);
  endtask

  task cmd(bbsr_pkg::action_t a, logic [11:0] s, logic [31:0] w, logic [31:0] x,
           logic [31:0] d, logic [15:0] k);
    raster_cmd_t c;
    c = '{act: a, slot: s, word: w, sx: x, sdepth: d, scale: k};
    send(c);
  endtask

  // APB write: setup cycle, then access cycle (pready is always high).
  task reg_write(bbsr_pkg::reg_idx_t idx, logic [31:0] val);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.set_reg(idx, val);
  endtask

  // Wait for every expected pixel, then let a pending start finish.
  task drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Well-formed start: depth 1..16 units, center within 40 columns of the
  // screen middle, height at most 7 rows, so width stays under 57 columns
  // for textures no larger than 8 by 8.
  task sane_start();
    logic [31:0] d;
    d = $urandom_range(32'h10000, 32'h100000);
    cmd(bbsr_pkg::ACT_START, $urandom, $urandom,
        $signed(d >> 3) - $signed($urandom_range(0, d >> 2)),
        d, $urandom_range(1, d >> 14));
  endtask

  task random_traffic(int count);
    int n, r, ticks;
    bbsr_pkg::action_t a;
    n = 0;
    while (n < count) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        // noise: any action, any field value; starts get a non-positive depth
        a = bbsr_pkg::action_t'($urandom_range(0, 3));
        cmd(a, $urandom, $urandom, $urandom,
            (a == bbsr_pkg::ACT_START) ? ($urandom | 32'h80000000) : $urandom, $urandom);
        n++;
      end else if (r < 18) begin
        cmd(bbsr_pkg::ACT_DEPTH, $urandom_range(0, 4095),
            ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h200000),
            $urandom, $urandom, $urandom);
        n++;
      end else if (r < 25) begin
        cmd(bbsr_pkg::ACT_TEXEL, $urandom,
            ($urandom_range(0, 5) == 0) ? bbsr_pkg::TRANSPARENT_KEY : $urandom,
            $urandom, $urandom, $urandom);
        n++;
      end else begin
        // a sprite followed by a run of ticks
        sane_start();
        ticks = $urandom_range(5, 80);
        repeat (ticks) cmd(bbsr_pkg::ACT_TICK, $urandom, $urandom, $urandom, $urandom,
                           $urandom);
        n += ticks + 1;
      end
    end
  endtask

  initial begin
    bbsr_pkg::reg_idx_t ri;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Small texture, so at most 64 texels are ever addressed.
    reg_write(bbsr_pkg::REG_TEX_WIDTH, 8);
    reg_write(bbsr_pkg::REG_TEX_HEIGHT, 8);

    // Preload every entry a sprite can reach.
    for (int i = COL_LO; i < COL_HI; i++)
      cmd(bbsr_pkg::ACT_DEPTH, i, (i % 97 == 0) ? 32'hFFFFFFFF : $urandom_range(0, 32'h200000),
          0, 0, 0);
    for (int i = 0; i < 64; i++)
      cmd(bbsr_pkg::ACT_TEXEL, i,
          ($urandom_range(0, 7) == 0) ? bbsr_pkg::TRANSPARENT_KEY : $urandom, 0, 0, 0);

    // Directed cases.
    cmd(bbsr_pkg::ACT_TICK, 0, 0, 0, 0, 0);                          // idle tick
    cmd(bbsr_pkg::ACT_DEPTH, 12'd640, 32'hFFFFFFFF, 0, 0, 0);        // out-of-range column
    cmd(bbsr_pkg::ACT_DEPTH, 12'hFFF, 32'h0, 0, 0, 0);
    cmd(bbsr_pkg::ACT_DEPTH, 12'd318, 32'h0, 0, 0, 0);               // column never passes
    cmd(bbsr_pkg::ACT_TEXEL, 12'd63, 32'h0, 0, 0, 0);                // black, still drawn
    cmd(bbsr_pkg::ACT_TEXEL, 12'd0, bbsr_pkg::TRANSPARENT_KEY, 0, 0, 0); // transparent key
    cmd(bbsr_pkg::ACT_START, 0, 0, 0, 32'h0, 16'h100);               // depth zero
    cmd(bbsr_pkg::ACT_TICK, 0, 0, 0, 0, 0);
    cmd(bbsr_pkg::ACT_START, 0, 0, 0, 32'h80000000, 16'hFFFF);       // negative depth
    cmd(bbsr_pkg::ACT_TICK, 0, 0, 0, 0, 0);
    cmd(bbsr_pkg::ACT_START, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h0); // zero span
    cmd(bbsr_pkg::ACT_TICK, 0, 0, 0, 0, 0);
    cmd(bbsr_pkg::ACT_START, 0, 0, 32'h80000000, 32'h1, 16'hFFFF);   // saturated spans
    cmd(bbsr_pkg::ACT_TICK, 0, 0, 0, 0, 0);
    cmd(bbsr_pkg::ACT_TICK, 0, 0, 0, 0, 0);
    cmd(bbsr_pkg::ACT_START, 0, 0, 32'h0, 32'h100000, 16'h40);       // tiny sprite, centered
    repeat (3) cmd(bbsr_pkg::ACT_TICK, 0, 0, 0, 0, 0);
    cmd(bbsr_pkg::ACT_DEPTH, 12'd320, 32'hFFFFFFFF, 0, 0, 0);        // write while busy
    cmd(bbsr_pkg::ACT_START, 0, 0, 32'h0, 32'h20000, 16'h4);         // start while busy
    repeat (6) cmd(bbsr_pkg::ACT_TICK, 0, 0, 0, 0, 0);
    drain();

    // Random phases over several texture shapes and idling mixes.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 16; recv_idle_pct = 70; end
        1: begin send_idle_pct = 70; recv_idle_pct = 16; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      ri = bbsr_pkg::REG_TEX_WIDTH;
      reg_write(ri, (p == 0) ? 8 : (p == 1) ? 8 : (p == 2) ? 1 : $urandom_range(1, 8));
      ri = bbsr_pkg::REG_TEX_HEIGHT;
      reg_write(ri, (p == 0) ? 8 : (p == 1) ? 1 : (p == 2) ? 8 : $urandom_range(1, 8));
      random_traffic(90);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS billboard_sprite_rasterizer_top");
    end else begin
      $display("FAIL billboard_sprite_rasterizer_top");
    end
    $finish;
  end
endmodule

// File: filelist.f
rtl/core/bbsr_pkg.sv
rtl/core/bbsr_ram.sv
rtl/core/bbsr_div.sv
rtl/core/billboard_sprite_rasterizer_top.sv
rtl/core/bbsr_checker.sv
bench/billboard_sprite_rasterizer_tb.sv
